>>> rtl/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg: shared definitions for the decimating peak meter
// Widths, register codes, detector modes and the configuration bundle.
// ----------------------------------------------------------------------------
package dpm_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int GAIN_BITS       = 16;
	localparam int GAIN_FRAC       = 12;
	localparam int LEN_BITS        = 16;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC);
	localparam logic [LEN_BITS-1:0]  LEN_RESET  = LEN_BITS'(1);

	localparam logic [CFG_IDX_BITS-1:0] CFG_MODE       = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN       = 2'd2;

	typedef enum logic [1:0] {
		MODE_ABS_MAX = 2'd0,
		MODE_ABS_MIN = 2'd1,
		MODE_MAG_MAX = 2'd2,
		MODE_MAG_MIN = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                mode;
		logic [LEN_BITS-1:0]  window_len;
		logic [GAIN_BITS-1:0] gain;
	} dpm_cfg_t;

endpackage

>>> rtl/dpm_if.sv
// ----------------------------------------------------------------------------
// dpm_if: stream channels of the decimating peak meter
// Sample input channel and meter result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpm_sample_if #(parameter int W = 24) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface dpm_meter_if #(parameter int W = 24) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] meter_value;

	modport source (output valid, output meter_value, input ready);
	modport sink (input valid, input meter_value, output ready);
endinterface

>>> rtl/dpm_front.sv
// ----------------------------------------------------------------------------
// dpm_front: sample intake and gain stage
// Multiplies each sample by the gain, rounds, saturates and derives the
// saturated absolute value and exact magnitude for the detector.
// ----------------------------------------------------------------------------
module dpm_front #(
	parameter int SAMPLE_BITS = dpm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dpm_pkg::dpm_cfg_t          cfg,
	dpm_sample_if.sink                 samples,
	output logic                       push,
	output logic [3*SAMPLE_BITS-1:0]   push_data,
	input  logic                       full
);
	import dpm_pkg::*;

	localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int RW = PW + 1;
	localparam int QW = RW - GAIN_FRAC;
	localparam int ROUND = 1 << (GAIN_FRAC - 1);

	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                    valid_s1;
	logic signed [PW-1:0]    prod_s1;
	logic signed [PW-1:0]    prod;
	logic signed [RW-1:0]    rounded;
	logic [QW-1:0]           quot;
	logic                    ovf;
	logic [SAMPLE_BITS-1:0]  scaled;
	logic [SAMPLE_BITS-1:0]  neg_val;
	logic [SAMPLE_BITS-1:0]  mag;
	logic [SAMPLE_BITS-1:0]  absv;

	assign samples.ready = !valid_s1 || !full;

	assign prod = PW'(signed'(samples.sample_in)) * PW'(signed'({1'b0, cfg.gain}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			prod_s1 <= prod;
		end
	end

	// round half up, floor shift, saturate
	always_comb begin
		rounded = RW'(prod_s1) + RW'(ROUND);
		quot    = rounded[RW-1:GAIN_FRAC];
		ovf     = !((&quot[QW-1:SAMPLE_BITS-1]) || !(|quot[QW-1:SAMPLE_BITS-1]));
		if (ovf) begin
			scaled = quot[QW-1] ? SMIN : SMAX;
		end else begin
			scaled = quot[SAMPLE_BITS-1:0];
		end
		neg_val = -scaled;
		mag     = scaled[SAMPLE_BITS-1] ? neg_val : scaled;
		absv    = (scaled[SAMPLE_BITS-1] && neg_val[SAMPLE_BITS-1]) ? SMAX : mag;
	end

	assign push      = valid_s1 && !full;
	assign push_data = {scaled, absv, mag};

endmodule

>>> rtl/dpm_fifo.sv
// ----------------------------------------------------------------------------
// dpm_fifo: short decoupling queue
// Register-based FIFO between the gain stage and the detector.
// ----------------------------------------------------------------------------
module dpm_fifo #(
	parameter int W     = 72,
	parameter int DEPTH = dpm_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         pop_valid,
	output logic [W-1:0] pop_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/dpm_back.sv
// ----------------------------------------------------------------------------
// dpm_back: extreme tracker and window counter
// Folds each scaled sample into the held extreme and emits it into the
// output register when the window closes.
// ----------------------------------------------------------------------------
module dpm_back #(
	parameter int SAMPLE_BITS = dpm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dpm_pkg::dpm_cfg_t         cfg,
	input  logic                      pop_valid,
	input  logic [3*SAMPLE_BITS-1:0]  pop_data,
	output logic                      pop,
	dpm_meter_if.source               meters
);
	import dpm_pkg::*;

	logic [SAMPLE_BITS-1:0] held_q;
	logic [LEN_BITS-1:0]    count_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] value_q;

	logic [SAMPLE_BITS-1:0] val;
	logic [SAMPLE_BITS-1:0] absv;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS-1:0] held_neg;
	logic [SAMPLE_BITS-1:0] held_mag;
	logic [SAMPLE_BITS-1:0] cand;
	logic                   take;
	logic                   first;
	logic [LEN_BITS:0]      nxt;
	logic                   close;
	logic [SAMPLE_BITS-1:0] new_held;

	assign {val, absv, mag} = pop_data;
	assign pop = pop_valid && (!out_valid_q || meters.ready);

	always_comb begin
		held_neg = -held_q;
		held_mag = held_q[SAMPLE_BITS-1] ? held_neg : held_q;
		case (cfg.mode)
			MODE_ABS_MAX: begin
				cand = absv;
				take = $signed(held_q) < $signed(absv);
			end
			MODE_ABS_MIN: begin
				cand = absv;
				take = $signed(held_q) > $signed(absv);
			end
			MODE_MAG_MAX: begin
				cand = val;
				take = held_mag < mag;
			end
			default: begin
				cand = val;
				take = held_mag > mag;
			end
		endcase
		first    = (count_q == '0);
		new_held = (first || take) ? cand : held_q;
		nxt      = {1'b0, count_q} + 1'b1;
		close    = nxt >= {1'b0, cfg.window_len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				held_q  <= new_held;
				count_q <= close ? '0 : nxt[LEN_BITS-1:0];
			end
			if (pop && close) begin
				out_valid_q <= 1'b1;
			end else if (meters.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && close) begin
			value_q <= new_held;
		end
	end

	assign meters.valid       = out_valid_q;
	assign meters.meter_value = value_q;

endmodule

>>> rtl/decimating_peak_meter.sv
// ----------------------------------------------------------------------------
// decimating_peak_meter: windowed min/max peak meter with gain
// Scales samples by a Q4.12 gain and emits one extreme per window.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one signed sample per beat (valid/ready).
//   meters:  one meter_value beat per closed window of window_len samples (0 acts as 1).
//   cfg_we/cfg_index/cfg_data: register writes (mode, window_len, gain),
//   taken at any edge with cfg_we high; write only while no sample or
//   meter beat is in flight.
// Throughput: one sample per cycle while the queue is not full, limited by
//   the gain multiplier stage and the tracker update.
// Path: meter_value becomes valid once the closing sample has passed the
//   multiplier register, the queue and the output register; a ready
//   receiver then takes it.
// Reset: registers return to mode 0, window_len 1, gain unity; the open
//   window, the queue and the output register are emptied.
// Stall: while meters.ready is low the output register holds its beat;
//   samples keep flowing until the 4-entry queue and the gain stage fill,
//   then samples.ready drops.
// ----------------------------------------------------------------------------
module decimating_peak_meter #(
	parameter int SAMPLE_BITS = dpm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dpm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [dpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	dpm_sample_if.sink                         samples,
	dpm_meter_if.source                        meters
);
	import dpm_pkg::*;

	localparam int QW = 3 * SAMPLE_BITS;

	dpm_cfg_t          cfg_q;
	logic              push;
	logic [QW-1:0]     push_data;
	logic              full;
	logic              pop;
	logic              pop_valid;
	logic [QW-1:0]     pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_ABS_MAX;
			cfg_q.window_len <= LEN_RESET;
			cfg_q.gain       <= GAIN_UNITY;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:       cfg_q.mode       <= mode_t'(cfg_data[1:0]);
				CFG_WINDOW_LEN: cfg_q.window_len <= cfg_data[LEN_BITS-1:0];
				CFG_GAIN:       cfg_q.gain       <= cfg_data[GAIN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	dpm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.samples   (samples),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	dpm_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	dpm_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.meters    (meters)
	);

endmodule

>>> rtl/dpm_checker.sv
// ----------------------------------------------------------------------------
// dpm_checker: port-level checks for the decimating peak meter
// Output handshake stability and no result without a pending sample.
// ----------------------------------------------------------------------------
module dpm_checker #(
	parameter int SAMPLE_BITS = dpm_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_value
);
	logic        in_beat;
	logic        out_beat;
	logic [31:0] pending_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// samples accepted whose windows have not yet produced a beat (upper bound)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_beat && !in_beat && pending_q != '0) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("meter beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value))
		else $error("meter value changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("meter beat without an accepted sample");

endmodule

bind decimating_peak_meter dpm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (meters.valid),
	.out_ready (meters.ready),
	.out_value (meters.meter_value)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for decimating_peak_meter
// Drives gained audio samples through the sample channel and checks every
// meter beat against an in-bench window tracker. Register settings change
// between idle phases. Directed extremes come first, then random phases with
// random stalls on both sides. One long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;

	import dpm_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE      = 8;
	localparam int ITEM_TARGET = 550;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
	localparam logic [SB-1:0] FULL_POS = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] FULL_NEG = {1'b1, {(SB-1){1'b0}}};
	localparam longint SAT_HI = (longint'(1) <<< (SB-1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	dpm_sample_if #(.W(SB)) samples_ch ();
	dpm_meter_if #(.W(SB))  meters_ch ();

	decimating_peak_meter #(.SAMPLE_BITS(SB)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.meters    (meters_ch)
	);

	// tracker state
	mode_t             trk_mode;
	logic [15:0]       trk_window_len;
	logic [15:0]       trk_gain;
	longint            trk_held;
	int unsigned       trk_count;

	logic [SB-1:0]     pending_samples[$];
	logic [SB-1:0]     expected_meters[$];

	bit                in_fire;
	bit                out_fire;
	bit                send_idle;
	bit                recv_idle;
	int                gap_left;
	int                stall_left;
	int                hold_left;
	int                hold_seq;
	int                hold_seen;
	int                quiet_cycles;
	int                errors;
	int                samples_taken;
	int                meters_checked;
	int                phases;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint clamp(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// fold one sample into the open window; returns 1 when the window closes
	function automatic bit fold_sample(input logic [SB-1:0] raw, output logic [SB-1:0] meter);
		longint      v;
		bit          first;
		bit          take;
		int unsigned nxt;
		v = clamp((longint'($signed(raw)) * longint'(trk_gain) + 2048) >>> 12);
		first = (trk_count == 0);
		case (trk_mode)
			MODE_ABS_MAX: begin
				v = (v < 0) ? clamp(-v) : v;
				take = trk_held < v;
			end
			MODE_ABS_MIN: begin
				v = (v < 0) ? clamp(-v) : v;
				take = trk_held > v;
			end
			MODE_MAG_MAX: take = magnitude(trk_held) < magnitude(v);
			default:      take = magnitude(trk_held) > magnitude(v);
		endcase
		if (first || take)
			trk_held = v;
		nxt = trk_count + 1;
		meter = SB'(trk_held);
		if (nxt >= trk_window_len) begin
			trk_count = 0;
			return 1'b1;
		end
		trk_count = nxt & 16'hFFFF;
		return 1'b0;
	endfunction

	task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_MODE:       trk_mode = mode_t'(val[1:0]);
			CFG_WINDOW_LEN: trk_window_len = val;
			CFG_GAIN:       trk_gain = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		errors++;
	endtask

	// wait for the block to go idle before touching registers
	task automatic drain();
		while (pending_samples.size() != 0 || samples_ch.valid || expected_meters.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		phases++;
	endtask

	function automatic logic [SB-1:0] pick_sample(input logic [SB-1:0] prev);
		case ($urandom_range(0, 9))
			0:       return FULL_POS;
			1:       return FULL_NEG;
			2:       return prev;
			3:       return -prev;
			4, 5:    return SB'(int'($urandom_range(0, 400)) - 200);
			default: return SB'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return GAIN_UNITY;
			3:       return 16'd2048;
			4, 5:    return 16'($urandom_range(2048, 8192));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_window();
		case ($urandom_range(0, 15))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(9, 64));
			default: return 16'($urandom_range(1, 8));
		endcase
	endfunction

	// sample driver
	always @(negedge clk) begin
		if (arst_n && (!samples_ch.valid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				samples_ch.valid <= 1'b0;
			end else if (send_idle && pending_samples.size() != 0 && $urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(1, 18) - 1;
				samples_ch.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				samples_ch.sample_in <= pending_samples.pop_front();
				samples_ch.valid     <= 1'b1;
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// meter receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			meters_ch.ready <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES - 1;
			meters_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			meters_ch.ready <= 1'b0;
		end else if (recv_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			meters_ch.ready <= 1'b0;
		end else begin
			meters_ch.ready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		logic [SB-1:0] meter;
		logic [SB-1:0] want;
		in_fire  = arst_n && samples_ch.valid && samples_ch.ready;
		out_fire = arst_n && meters_ch.valid && meters_ch.ready;
		if (in_fire) begin
			samples_taken++;
			if (fold_sample(samples_ch.sample_in, meter))
				expected_meters.push_back(meter);
		end
		if (out_fire) begin
			if (expected_meters.size() == 0) begin
				report_mismatch($sformatf("unexpected meter beat, meter_value %0d",
					$signed(meters_ch.meter_value)));
			end else begin
				want = expected_meters.pop_front();
				if (meters_ch.meter_value !== want)
					report_mismatch($sformatf("beat %0d: meter_value got %0d expected %0d",
						meters_checked, $signed(meters_ch.meter_value), $signed(want)));
				meters_checked++;
			end
		end
		if (in_fire || out_fire || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout after %0d quiet cycles", quiet_cycles);
		$display("decimating_peak_meter verification failed");
		$finish;
	end

	initial begin
		int          queued;
		int          n;
		logic [SB-1:0] prev;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_MODE;
		cfg_data             = '0;
		samples_ch.valid     = 1'b0;
		samples_ch.sample_in = '0;
		meters_ch.ready      = 1'b0;
		trk_mode             = MODE_ABS_MAX;
		trk_window_len       = LEN_RESET;
		trk_gain             = GAIN_UNITY;
		trk_held             = 0;
		trk_count            = 0;
		send_idle            = 1'b1;
		recv_idle            = 1'b1;
		queued               = 0;
		prev                 = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: abs max, every sample emitted, unity gain
		pending_samples = '{FULL_POS, FULL_NEG, SB'(0), SB'(-1), SB'(1)};
		drain();
		write_register(CFG_SPARE, 16'hA5C3);
		write_register(CFG_MODE, {14'h3FFF, MODE_MAG_MAX});
		write_register(CFG_WINDOW_LEN, 16'd3);
		pending_samples = '{FULL_NEG, FULL_POS, SB'(5)};
		drain();
		write_register(CFG_MODE, 16'(MODE_MAG_MIN));
		pending_samples = '{SB'(7), SB'(-7), SB'(9)};
		drain();
		write_register(CFG_MODE, 16'(MODE_ABS_MIN));
		write_register(CFG_WINDOW_LEN, 16'd2);
		pending_samples = '{SB'(-4), SB'(4)};
		drain();
		// half gain: rounding ties go up
		write_register(CFG_MODE, 16'(MODE_MAG_MAX));
		write_register(CFG_WINDOW_LEN, 16'd0);
		write_register(CFG_GAIN, 16'd2048);
		pending_samples = '{SB'(1), SB'(-1), SB'(3), SB'(-3)};
		drain();
		write_register(CFG_MODE, 16'(MODE_ABS_MAX));
		write_register(CFG_WINDOW_LEN, 16'd1);
		write_register(CFG_GAIN, 16'hFFFF);
		pending_samples = '{FULL_POS, FULL_NEG, SB'(1)};
		drain();
		write_register(CFG_GAIN, 16'd0);
		pending_samples = '{SB'(12345)};
		drain();

		while (queued < ITEM_TARGET) begin
			if (queued >= ITEM_TARGET - 100) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end else begin
				send_idle = $urandom_range(0, 3) != 0;
				recv_idle = $urandom_range(0, 3) != 0;
			end
			if (phases == 7) begin
				// long window, then shorten it below the count
				write_register(CFG_GAIN, GAIN_UNITY);
				write_register(CFG_WINDOW_LEN, 16'hFFFF);
			end else if (phases == 8) begin
				write_register(CFG_WINDOW_LEN, 16'd3);
			end else if (phases == 10) begin
				// receiver holds off while samples keep coming
				send_idle = 1'b0;
				recv_idle = 1'b0;
				write_register(CFG_WINDOW_LEN, 16'd1);
				hold_seq++;
			end else begin
				if ($urandom_range(0, 1))
					write_register(CFG_MODE, {14'($urandom), 2'($urandom_range(0, 3))});
				if ($urandom_range(0, 1))
					write_register(CFG_WINDOW_LEN, pick_window());
				if ($urandom_range(0, 1))
					write_register(CFG_GAIN, pick_gain());
			end
			n = (phases == 10) ? 40 : $urandom_range(10, 40);
			repeat (n) begin
				prev = pick_sample(prev);
				pending_samples.push_back(prev);
			end
			queued += n;
			drain();
		end

		repeat (20) @(posedge clk);
		$display("%0d samples in, %0d meter values checked, %0d register phases", samples_taken,
			meters_checked, phases);
		$display("covered all modes, window lengths 0 to 65535, gains 0 to 65535, full hold-off");
		if (errors == 0) begin
			$display("decimating_peak_meter verification clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("decimating_peak_meter verification failed");
		end
		$finish;
	end

endmodule
